>>> hdl/bitmap_run_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap run allocator assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Field widths, register indexes, transaction codes and map geometry.
// ----------------------------------------------------------------------------
package bra_pkg;

    // Field widths of the configuration and transaction ports.
    localparam int ADDR_W    = 32;
    localparam int UNIT_W    = 17;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Occupancy map geometry: one memory row holds eight slots.
    localparam int ROW_SLOTS = 8;
    localparam int ROW_SHIFT = 3;

    // Transaction modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd2;

endpackage

>>> hdl/bra_div.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator divider
// Restoring divider that turns an address offset into a slot index, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bra_div
    import bra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [UNIT_W-1:0] divisor,
    output logic              done,
    output logic [ADDR_W-1:0] quotient
);

    localparam int STEP_W = $clog2(ADDR_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

    logic              run_reg;
    logic [STEP_W-1:0] count_reg;
    logic              done_reg;
    logic [UNIT_W-1:0] rem_reg;
    logic [UNIT_W-1:0] rem_next;
    logic [ADDR_W-1:0] quo_reg;
    logic              quo_bit;
    logic [UNIT_W:0]   shifted;
    logic [UNIT_W:0]   trial;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[ADDR_W-1]};
        if (shifted >= {1'b0, divisor})
        begin
            trial   = shifted - {1'b0, divisor};
            quo_bit = 1'b1;
        end
        else
        begin
            trial   = shifted;
            quo_bit = 1'b0;
        end
        rem_next = trial[UNIT_W-1:0];
    end

    // Step counter and completion strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && !start && (count_reg == LAST_STEP);
            if (start)
            begin
                run_reg   <= 1'b1;
                count_reg <= '0;
            end
            else if (run_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Partial remainder and quotient, which shares the dividend register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], quo_bit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator
// First-fit allocator of contiguous slot runs over an occupancy map memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. mode selects an
// allocate or a free of run_length slots; free_address is used on a free only.
// Each transaction gives one result on granted_address and failed, shown for
// one cycle with done high. The receiver cannot hold results off.
// The map sits in a memory of eight-slot rows with a registered read. An
// allocate streams rows through the first-fit scan, one row per cycle, then
// writes the run back with a read-modify-write sweep over its rows.
// A free first divides the address offset by the unit size, one bit per
// cycle, then sweeps the rows of the run the same way.
// A zero or oversized allocate, and a free with unit size zero, answer in
// the cycle after the transaction. One transaction is worked on at a time.
// Reset clears the per-row valid bits at once, so the whole map reads free
// with no clearing pass. Configuration must be written only while busy is low;
// the block itself does not enforce this.
`include "bitmap_run_allocator_defines.svh"

module bitmap_run_allocator
    import bra_pkg::*;
#(
    parameter int SLOT_COUNT = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [COUNT_W-1:0]   run_length,
    input  logic [ADDR_W-1:0]    free_address,
    output logic                 done,
    output logic [ADDR_W-1:0]    granted_address,
    output logic                 failed
);

    localparam int ROWS   = (SLOT_COUNT + ROW_SLOTS - 1) / ROW_SLOTS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IR_W   = $clog2(ROWS + 1);
    localparam int SW     = $clog2(ROWS * ROW_SLOTS + 1);
    localparam int PROD_W = SW + UNIT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_MARK = 4'b1000
    } state_t;

    // Control registers.
    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic                pend_reg, pend_next;
    logic [IR_W-1:0]     issue_row_reg, issue_row_next;
    logic [ROWS-1:0]     row_valid_reg;

    // Configuration registers.
    logic [ADDR_W-1:0]   base_address_reg;
    logic [UNIT_W-1:0]   unit_size_reg;
    logic [COUNT_W-1:0]  slots_in_use_reg;

    // Working registers of the current transaction.
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [SW-1:0]       cap_reg, cap_next;
    logic [COUNT_W-1:0]  run_reg, run_next;
    logic [ROW_W-1:0]    eval_row_reg, eval_row_next;
    logic [SW-1:0]       lo_reg, lo_next;
    logic [SW-1:0]       hi_reg, hi_next;
    logic [ROW_W-1:0]    last_row_reg, last_row_next;
    logic                set_reg, set_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0]   granted_reg, granted_next;
    logic                failed_reg, failed_next;

    // Map memory and its read port.
    logic [ROW_SLOTS-1:0] map_mem [ROWS];
    logic [ROW_SLOTS-1:0] rdata_reg;
    logic                 rvalid_reg;
    logic [ROW_SLOTS-1:0] row_q;
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_row;
    logic                 mem_we;
    logic [ROW_W-1:0]     wr_row;
    logic [ROW_SLOTS-1:0] wr_data;

    // Scan and sweep helpers.
    logic [SW-1:0]        cap_in;
    logic [COUNT_W-1:0]   scan_run;
    logic                 scan_found;
    logic [SW-1:0]        scan_hit;
    logic [SW-1:0]        scan_lo;
    logic [SW-1:0]        scan_hi;
    logic                 scan_exhausted;
    logic [ROW_SLOTS-1:0] mark_mask;
    logic [ADDR_W-1:0]    free_hi;
    logic [SW-1:0]        div_hi;

    // Divider interface.
    logic                 div_start;
    logic [ADDR_W-1:0]    div_dividend;
    logic                 div_done;
    logic [ADDR_W-1:0]    div_quotient;

    bra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (unit_size_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // A row never written since reset reads as all free.
    assign row_q = rvalid_reg ? rdata_reg : '0;

    // Capacity in use, limited to the built slot count.
    always_comb
    begin
        if (32'(slots_in_use_reg) > 32'(SLOT_COUNT))
        begin
            cap_in = SW'(SLOT_COUNT);
        end
        else
        begin
            cap_in = SW'(slots_in_use_reg);
        end
    end

    // First-fit scan of one row: extend the free run slot by slot.
    always_comb
    begin
        logic [SW-1:0] slot;
        scan_run   = run_reg;
        scan_found = 1'b0;
        scan_hit   = '0;
        for (int b = 0; b < ROW_SLOTS; b++)
        begin
            slot = SW'({eval_row_reg, 3'(b)});
            if (!scan_found && (slot < cap_reg))
            begin
                if (row_q[b])
                begin
                    scan_run = '0;
                end
                else
                begin
                    scan_run = scan_run + 1'b1;
                    if (scan_run == n_reg)
                    begin
                        scan_found = 1'b1;
                        scan_hit   = slot;
                    end
                end
            end
        end
        scan_exhausted = (32'({eval_row_reg, 3'b111}) + 32'd1) >= 32'(cap_reg);
        scan_lo        = SW'(32'(scan_hit) + 32'd1 - 32'(n_reg));
        scan_hi        = scan_hit + 1'b1;
    end

    // Slots of the current sweep row that fall inside the run.
    always_comb
    begin
        logic [SW-1:0] slot;
        for (int b = 0; b < ROW_SLOTS; b++)
        begin
            slot         = SW'({eval_row_reg, 3'(b)});
            mark_mask[b] = (slot >= lo_reg) && (slot < hi_reg);
        end
    end

    // End of a free run, clipped to the capacity in use.
    always_comb
    begin
        free_hi = div_quotient + 32'(n_reg);
        if (free_hi > 32'(cap_reg))
        begin
            div_hi = cap_reg;
        end
        else
        begin
            div_hi = SW'(free_hi);
        end
    end

    // Transaction sequencer.
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        pend_next      = pend_reg;
        issue_row_next = issue_row_reg;
        n_next         = n_reg;
        cap_next       = cap_reg;
        run_next       = run_reg;
        eval_row_next  = eval_row_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        last_row_next  = last_row_reg;
        set_next       = set_reg;
        prod_next      = prod_reg;
        granted_next   = granted_reg;
        failed_next    = failed_reg;
        rd_en          = 1'b0;
        rd_row         = ROW_W'(issue_row_reg);
        mem_we         = 1'b0;
        wr_row         = eval_row_reg;
        wr_data        = set_reg ? (row_q | mark_mask) : (row_q & ~mark_mask);
        div_start      = 1'b0;
        div_dividend   = free_address - base_address_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cap_next = cap_in;
                    n_next   = run_length;
                    if (mode == MODE_ALLOC)
                    begin
                        set_next = 1'b1;
                        if ((run_length == '0) || (32'(run_length) > 32'(cap_in)))
                        begin
                            done_next    = 1'b1;
                            failed_next  = 1'b1;
                            granted_next = '0;
                        end
                        else
                        begin
                            state_next     = S_SCAN;
                            run_next       = '0;
                            issue_row_next = '0;
                            pend_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        set_next = 1'b0;
                        if (unit_size_reg == '0)
                        begin
                            done_next    = 1'b1;
                            failed_next  = 1'b0;
                            granted_next = '0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Stream row reads; evaluate the row that arrived this cycle.
                eval_row_next = ROW_W'(issue_row_reg);
                if (issue_row_reg < IR_W'(ROWS))
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    issue_row_next = issue_row_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (scan_found)
                    begin
                        state_next     = S_MARK;
                        rd_en          = 1'b0;
                        pend_next      = 1'b0;
                        lo_next        = scan_lo;
                        hi_next        = scan_hi;
                        last_row_next  = ROW_W'((scan_hi - 1'b1) >> ROW_SHIFT);
                        issue_row_next = IR_W'(scan_lo >> ROW_SHIFT);
                    end
                    else if (scan_exhausted)
                    begin
                        state_next   = S_IDLE;
                        rd_en        = 1'b0;
                        pend_next    = 1'b0;
                        done_next    = 1'b1;
                        failed_next  = 1'b1;
                        granted_next = '0;
                    end
                    else
                    begin
                        run_next = scan_run;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if ((div_quotient >= 32'(cap_reg)) || (n_reg == '0))
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        failed_next  = 1'b0;
                        granted_next = '0;
                    end
                    else
                    begin
                        state_next     = S_MARK;
                        pend_next      = 1'b0;
                        lo_next        = SW'(div_quotient);
                        hi_next        = div_hi;
                        last_row_next  = ROW_W'((div_hi - 1'b1) >> ROW_SHIFT);
                        issue_row_next = IR_W'(SW'(div_quotient) >> ROW_SHIFT);
                    end
                end
            end

            S_MARK:
            begin
                // Read-modify-write sweep: read the next row, write back this one.
                prod_next     = PROD_W'(lo_reg) * PROD_W'(unit_size_reg);
                eval_row_next = ROW_W'(issue_row_reg);
                if (issue_row_reg <= IR_W'(last_row_reg))
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    issue_row_next = issue_row_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    if (eval_row_reg == last_row_reg)
                    begin
                        state_next  = S_IDLE;
                        pend_next   = 1'b0;
                        done_next   = 1'b1;
                        failed_next = 1'b0;
                        if (set_reg)
                        begin
                            granted_next = base_address_reg + 32'(prod_reg);
                        end
                        else
                        begin
                            granted_next = '0;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    // Control state and per-row valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            issue_row_reg <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            issue_row_reg <= issue_row_next;
            if (mem_we)
            begin
                row_valid_reg[wr_row] <= 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            unit_size_reg    <= UNIT_W'(4096);
            slots_in_use_reg <= COUNT_W'(256);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                REG_UNIT_SIZE:    unit_size_reg    <= cfg_data[UNIT_W-1:0];
                REG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Transaction working data and result payload.
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        cap_reg      <= cap_next;
        run_reg      <= run_next;
        eval_row_reg <= eval_row_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        last_row_reg <= last_row_next;
        set_reg      <= set_next;
        prod_reg     <= prod_next;
        granted_reg  <= granted_next;
        failed_reg   <= failed_next;
    end

    // Occupancy map memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_row] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg  <= map_mem[rd_row];
            rvalid_reg <= row_valid_reg[rd_row];
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign granted_address = granted_reg;
    assign failed          = failed_reg;

    // A failed result never carries an address.
    `BRA_ASSERT_NOW(a_fail_no_addr, clk, rst_n, done && failed, granted_address == '0, "failed result carries an address")

    // The sweep never reads the row it writes back in the same cycle.
    `BRA_ASSERT_NOW(a_rmw_rows_apart, clk, rst_n, mem_we && rd_en, wr_row != rd_row, "read and write hit one row")

    // The divider only finishes while a free waits for it.
    `BRA_ASSERT_NOW(a_div_in_free, clk, rst_n, div_done, state_reg == S_DIV, "divider done outside a free")

    // Starting the divider always leads into the wait for its quotient.
    `BRA_ASSERT_NEXT(a_div_start, clk, rst_n, div_start, state_reg == S_DIV, "divider started without waiting")

endmodule
